// ===== design/lps_pkg.sv =====
// package: constants, types, pattern rom and helper functions for the led sequencer
`timescale 1ns / 1ps
package lps_pkg;

  localparam int LED_COUNT     = 5;
  localparam int PATTERN_COUNT = 6;
  localparam int WAIT_BITS     = 16;
  localparam int STEP_LIMIT    = 32;

  localparam int OP_W     = 2;
  localparam int LED_W    = 3;
  localparam int PAT_W    = 3;
  localparam int POS_W    = 3;
  localparam int LEVELS_W = 5;
  localparam int GUARD_W  = $clog2(STEP_LIMIT);

  localparam logic [OP_W-1:0] OP_RUN  = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [PAT_W-1:0] NONE_ACTIVE = 3'd6;
  localparam logic [POS_W-1:0] POS_STOPPED = 3'd7;
  localparam logic [POS_W-1:0] POS_FIRST   = 3'd0;

  typedef enum logic [1:0] {
    KIND_WAIT,
    KIND_LOOP,
    KIND_STOP
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 lvl;
    logic [WAIT_BITS-1:0] ms;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK,
    ST_EXEC,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [PAT_W-1:0]         pat;
    logic [POS_W-1:0]         pos;
    logic [PATTERN_COUNT-1:0] running;
  } step_req_t;

  typedef struct packed {
    logic [POS_W-1:0]     pos_nxt;
    logic [PAT_W-1:0]     active_nxt;
    logic                 level_nxt;
    logic                 wait_load;
    logic [WAIT_BITS-1:0] wait_val;
    logic                 finish;
  } step_rsp_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] led_levels;
    logic [PAT_W-1:0]    active_pattern;
    logic                accepted;
  } result_t;

  function automatic step_t mk_step(kind_t kind, logic lvl, int ms);
    step_t s;
    s.kind = kind;
    s.lvl  = lvl;
    s.ms   = WAIT_BITS'(ms);
    return s;
  endfunction

  // pattern rom, a position past the table reads as a stop step
  function automatic step_t rom_step(logic [PAT_W-1:0] p, logic [POS_W-1:0] pos);
    step_t s;
    s = mk_step(KIND_STOP, 1'b0, 0);
    case (p)
      3'd0, 3'd1: begin
        case (pos)
          3'd0:    s = mk_step(KIND_WAIT, 1'b1, 1000);
          3'd1:    s = mk_step(KIND_LOOP, 1'b0, 0);
          default: s = mk_step(KIND_STOP, 1'b0, 0);
        endcase
      end
      3'd2: begin
        case (pos)
          3'd0:    s = mk_step(KIND_WAIT, 1'b1, 200);
          3'd1:    s = mk_step(KIND_WAIT, 1'b0, 800);
          3'd2:    s = mk_step(KIND_LOOP, 1'b0, 0);
          default: s = mk_step(KIND_STOP, 1'b0, 0);
        endcase
      end
      3'd3: begin
        case (pos)
          3'd0:    s = mk_step(KIND_WAIT, 1'b1, 50);
          3'd1:    s = mk_step(KIND_WAIT, 1'b0, 450);
          3'd2:    s = mk_step(KIND_LOOP, 1'b0, 0);
          default: s = mk_step(KIND_STOP, 1'b0, 0);
        endcase
      end
      3'd4: begin
        case (pos)
          3'd0:    s = mk_step(KIND_WAIT, 1'b1, 50);
          3'd1:    s = mk_step(KIND_WAIT, 1'b0, 1950);
          3'd2:    s = mk_step(KIND_LOOP, 1'b0, 0);
          default: s = mk_step(KIND_STOP, 1'b0, 0);
        endcase
      end
      3'd5: begin
        case (pos)
          3'd0:    s = mk_step(KIND_WAIT, 1'b1, 1);
          3'd1:    s = mk_step(KIND_WAIT, 1'b0, 0);
          default: s = mk_step(KIND_STOP, 1'b0, 0);
        endcase
      end
      default: s = mk_step(KIND_STOP, 1'b0, 0);
    endcase
    return s;
  endfunction

  // lowest-index running pattern, none if all stopped
  function automatic logic [PAT_W-1:0] first_running(logic [PATTERN_COUNT-1:0] row);
    logic [PAT_W-1:0] res;
    res = NONE_ACTIVE;
    for (int p = PATTERN_COUNT - 1; p >= 0; p--) begin
      if (row[p]) begin
        res = PAT_W'(p);
      end
    end
    return res;
  endfunction

endpackage

// ===== design/lps_in_if.sv =====
// interfaces: command/tick item channel and result item channel
`timescale 1ns / 1ps
interface lps_in_if import lps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [LED_W-1:0] led;
  logic [PAT_W-1:0] pattern;

  modport source (output valid, op, led, pattern, input ready);
  modport sink (input valid, op, led, pattern, output ready);
endinterface

interface lps_out_if import lps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] led_levels;
  logic [PAT_W-1:0]    active_pattern;
  logic                accepted;

  modport source (output valid, led_levels, active_pattern, accepted, input ready);
  modport sink (input valid, led_levels, active_pattern, accepted, output ready);
endinterface

// ===== design/lps_step.sv =====
// shared step unit: one pattern step from rom, next position, level, wait and handover
`timescale 1ns / 1ps
module lps_step import lps_pkg::*; (
  input  step_req_t req,
  input  logic      level_cur,
  output step_rsp_t rsp
);

  step_t s;

  always_comb begin
    s              = rom_step(req.pat, req.pos);
    rsp.pos_nxt    = POS_W'(req.pos + 1'b1);
    rsp.active_nxt = req.pat;
    rsp.level_nxt  = level_cur;
    rsp.wait_load  = 1'b0;
    rsp.wait_val   = s.ms;
    rsp.finish     = 1'b0;
    unique case (s.kind)
      KIND_WAIT: begin
        rsp.level_nxt = s.lvl;
        if (s.ms != '0) begin
          rsp.wait_load = 1'b1;
          rsp.finish    = 1'b1;
        end
      end
      KIND_LOOP: begin
        rsp.pos_nxt = POS_FIRST;
      end
      default: begin
        // stop step hands the led to the next running pattern
        rsp.pos_nxt    = POS_STOPPED;
        rsp.active_nxt = first_running(req.running & ~(PATTERN_COUNT'(1) << req.pat));
        rsp.level_nxt  = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/lps_seq.sv =====
// sequencer: led state storage and the control that walks commands, ticks and steps
`timescale 1ns / 1ps
module lps_seq import lps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [OP_W-1:0]  in_op,
  input  logic [LED_W-1:0] in_led,
  input  logic [PAT_W-1:0] in_pat,
  input  logic             enable,
  input  logic             out_free,
  output logic             idle,
  output logic             res_load,
  output result_t          res
);

  seq_state_t state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [LED_W-1:0]   led_r, led_nxt;
  logic [PAT_W-1:0]   pat_r, pat_nxt;
  logic               ok_r, ok_nxt;
  logic [LED_W-1:0]   cur_r, cur_nxt;
  logic [GUARD_W-1:0] guard_r, guard_nxt;
  logic               from_tick_r, from_tick_nxt;

  logic [POS_W-1:0]     position_r [LED_COUNT][PATTERN_COUNT];
  logic [PAT_W-1:0]     active_r [LED_COUNT];
  logic [WAIT_BITS-1:0] wait_r [LED_COUNT];
  logic [LED_COUNT-1:0] level_r;

  logic                 pos_we;
  logic [PAT_W-1:0]     pos_pat;
  logic [POS_W-1:0]     pos_val;
  logic                 act_we;
  logic [PAT_W-1:0]     act_val;
  logic                 lvl_we;
  logic                 lvl_val;
  logic                 wait_we;
  logic [WAIT_BITS-1:0] wait_val;

  logic [PATTERN_COUNT-1:0] running;
  logic [PATTERN_COUNT-1:0] cmd_running;
  logic [PAT_W-1:0]         cmd_active;
  logic [PAT_W-1:0]         cur_active;
  logic [WAIT_BITS-1:0]     cur_wait;
  logic                     cmd_valid;
  logic                     last_led;
  step_req_t                req;
  step_rsp_t                rsp;

  lps_step u_step (
    .req       (req),
    .level_cur (level_r[cur_r]),
    .rsp       (rsp)
  );

  always_comb begin
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      running[p] = (position_r[cur_r][p] != POS_STOPPED);
    end
    cur_active  = active_r[cur_r];
    cur_wait    = wait_r[cur_r];
    req.pat     = cur_active;
    req.pos     = (cur_active < PAT_W'(PATTERN_COUNT)) ? position_r[cur_r][cur_active]
                                                       : POS_STOPPED;
    req.running = running;
    if (op_r == OP_RUN) begin
      cmd_running = running | (PATTERN_COUNT'(1) << pat_r);
    end else begin
      cmd_running = running & ~(PATTERN_COUNT'(1) << pat_r);
    end
    cmd_active = first_running(cmd_running);
    cmd_valid  = ((in_op == OP_RUN) || (in_op == OP_STOP)) &&
                 (in_led < LED_W'(LED_COUNT)) && (in_pat < PAT_W'(PATTERN_COUNT));
    last_led   = (cur_r == LED_W'(LED_COUNT - 1));
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    led_nxt       = led_r;
    pat_nxt       = pat_r;
    ok_nxt        = ok_r;
    cur_nxt       = cur_r;
    guard_nxt     = guard_r;
    from_tick_nxt = from_tick_r;
    pos_we        = 1'b0;
    pos_pat       = cur_active;
    pos_val       = rsp.pos_nxt;
    act_we        = 1'b0;
    act_val       = rsp.active_nxt;
    lvl_we        = 1'b0;
    lvl_val       = rsp.level_nxt;
    wait_we       = 1'b0;
    wait_val      = rsp.wait_val;
    idle          = 1'b0;
    res_load      = 1'b0;
    res.led_levels     = LEVELS_W'(level_r);
    res.active_pattern = (led_r < LED_W'(LED_COUNT)) ? active_r[led_r] : NONE_ACTIVE;
    res.accepted       = ok_r;
    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          op_nxt        = in_op;
          led_nxt       = in_led;
          pat_nxt       = in_pat;
          from_tick_nxt = (in_op == OP_TICK);
          ok_nxt        = (in_op == OP_TICK) || cmd_valid;
          if (in_op == OP_TICK) begin
            cur_nxt   = '0;
            state_nxt = ST_TICK;
          end else if (cmd_valid) begin
            cur_nxt   = in_led;
            state_nxt = ST_CMD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CMD: begin
        pos_we    = 1'b1;
        pos_pat   = pat_r;
        pos_val   = (op_r == OP_RUN) ? POS_FIRST : POS_STOPPED;
        act_we    = 1'b1;
        act_val   = cmd_active;
        lvl_we    = 1'b1;
        lvl_val   = 1'b0;
        guard_nxt = '0;
        if ((op_r == OP_STOP) || (cmd_active == pat_r)) begin
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_TICK: begin
        if (cur_wait != '0) begin
          wait_we  = 1'b1;
          wait_val = WAIT_BITS'(cur_wait - 1'b1);
        end
        if (cur_wait == WAIT_BITS'(1)) begin
          guard_nxt = '0;
          state_nxt = ST_EXEC;
        end else if (last_led) begin
          state_nxt = ST_DONE;
        end else begin
          cur_nxt = LED_W'(cur_r + 1'b1);
        end
      end
      ST_EXEC: begin
        if (!enable || (cur_active >= PAT_W'(PATTERN_COUNT)) ||
            (rsp.finish && enable) || (guard_r == GUARD_W'(STEP_LIMIT - 1))) begin
          if (from_tick_r && !last_led) begin
            cur_nxt   = LED_W'(cur_r + 1'b1);
            state_nxt = ST_TICK;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          guard_nxt = GUARD_W'(guard_r + 1'b1);
        end
        if (enable && (cur_active < PAT_W'(PATTERN_COUNT))) begin
          pos_we  = 1'b1;
          act_we  = 1'b1;
          lvl_we  = 1'b1;
          wait_we = rsp.wait_load;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      from_tick_r <= 1'b0;
      guard_r     <= '0;
      cur_r       <= '0;
      level_r     <= '0;
      for (int n = 0; n < LED_COUNT; n++) begin
        active_r[n] <= NONE_ACTIVE;
        wait_r[n]   <= '0;
        for (int p = 0; p < PATTERN_COUNT; p++) begin
          position_r[n][p] <= POS_STOPPED;
        end
      end
    end else begin
      state_r     <= state_nxt;
      from_tick_r <= from_tick_nxt;
      guard_r     <= guard_nxt;
      cur_r       <= cur_nxt;
      if (pos_we) begin
        position_r[cur_r][pos_pat] <= pos_val;
      end
      if (act_we) begin
        active_r[cur_r] <= act_val;
      end
      if (lvl_we) begin
        level_r[cur_r] <= lvl_val;
      end
      if (wait_we) begin
        wait_r[cur_r] <= wait_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    led_r <= led_nxt;
    pat_r <= pat_nxt;
    ok_r  <= ok_nxt;
  end

endmodule

// ===== design/led_priority_sequencer_unit.sv =====
// top level: led priority blink sequencer with item channels and enable register
`timescale 1ns / 1ps
// Plays the built-in blink patterns on five LEDs; each LED follows its lowest-index running
// pattern. Items are run, stop or one-millisecond tick, and every item gives one result item
// with all LED levels, the addressed LED's active pattern and an accepted flag. Work goes
// through one shared step unit under a small sequencer, one item at a time: a run or stop
// passes the command state, then the step state for each pattern step carried out, then the
// done state; a tick visits the LEDs in turn and carries out the pattern steps of every LED
// whose wait runs out; an invalid item goes straight to the done state. A new item is taken
// while the previous result still waits in the output register. The enable register may be
// written only while the block is idle.
module led_priority_sequencer_unit import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_ch,
  lps_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic    enable_r;
  logic    out_valid_r;
  result_t out_r;
  logic    seq_idle;
  logic    res_load;
  result_t res;
  logic    in_fire;
  logic    out_free;

  assign in_ch.ready = seq_idle;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  lps_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_op    (in_ch.op),
    .in_led   (in_ch.led),
    .in_pat   (in_ch.pattern),
    .enable   (enable_r),
    .out_free (out_free),
    .idle     (seq_idle),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.led_levels     = out_r.led_levels;
  assign out_ch.active_pattern = out_r.active_pattern;
  assign out_ch.accepted       = out_r.accepted;

endmodule

// ===== design/lps_checker.sv =====
// checker: port-level assertions for the led sequencer, bound to the top level
`timescale 1ns / 1ps
module lps_checker import lps_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [LEVELS_W-1:0] led_levels,
  input logic [PAT_W-1:0]    active_pattern,
  input logic                accepted
);

  // a waiting result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(led_levels) &&
    $stable(active_pattern) && $stable(accepted))
    else $error("result item changed while stalled");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> active_pattern <= NONE_ACTIVE)
    else $error("active pattern out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // one item is taken only after the previous one has left the sequencer
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

endmodule

bind led_priority_sequencer_unit lps_checker u_lps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .led_levels     (out_ch.led_levels),
  .active_pattern (out_ch.active_pattern),
  .accepted       (out_ch.accepted)
);

// ===== tb/sv/lps_result_check.sv =====
// checker: watches both item channels, predicts every result item and compares it
`timescale 1ns / 1ps
module lps_result_check import lps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lps_in_if    cmd_mon,
  lps_out_if   res_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   mismatch_count,
  output int   results_pending,
  output int   results_checked,
  output int   steps_predicted
);
  localparam int REPORT_MAX = 10;

  logic [POS_W-1:0]     step_pos [LED_COUNT][PATTERN_COUNT];
  logic [PAT_W-1:0]     lead_pat [LED_COUNT];
  logic [WAIT_BITS-1:0] ms_left  [LED_COUNT];
  logic                 lit      [LED_COUNT];
  logic                 seq_enable;
  result_t              levels_due [$];
  result_t              seen;
  result_t              due;

  function automatic step_t blink_step(logic [PAT_W-1:0] p, logic [POS_W-1:0] pos);
    step_t s;
    int    on_ms;
    int    off_ms;
    bit    two_phase;
    bit    loops;
    on_ms  = 0;
    off_ms = 0;
    case (p)
      3'd0, 3'd1: on_ms = 1000;
      3'd2: begin
        on_ms  = 200;
        off_ms = 800;
      end
      3'd3: begin
        on_ms  = 50;
        off_ms = 450;
      end
      3'd4: begin
        on_ms  = 50;
        off_ms = 1950;
      end
      3'd5: on_ms = 1;
      default: ;
    endcase
    two_phase = (p >= 3'd2);
    loops     = (p != 3'd5);
    s.kind = KIND_STOP;
    s.lvl  = 1'b0;
    s.ms   = '0;
    if (p < PATTERN_COUNT) begin
      if (pos == 3'd0) begin
        s.kind = KIND_WAIT;
        s.lvl  = 1'b1;
        s.ms   = WAIT_BITS'(on_ms);
      end else if (pos == 3'd1) begin
        if (two_phase) begin
          s.kind = KIND_WAIT;
          s.ms   = WAIT_BITS'(off_ms);
        end else begin
          s.kind = KIND_LOOP;
        end
      end else if (pos == 3'd2 && two_phase && loops) begin
        s.kind = KIND_LOOP;
      end
    end
    return s;
  endfunction

  function automatic void pick_lead(int n);
    bit found;
    found       = 1'b0;
    lit[n]      = 1'b0;
    lead_pat[n] = NONE_ACTIVE;
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      if (!found && step_pos[n][p] != POS_STOPPED) begin
        lead_pat[n] = PAT_W'(p);
        found       = 1'b1;
      end
    end
  endfunction

  function automatic void play_steps(int n);
    logic [PAT_W-1:0] p;
    logic [POS_W-1:0] pos;
    step_t            s;
    bit               halt;
    halt = !seq_enable;
    for (int g = 0; g < STEP_LIMIT && !halt; g++) begin
      p = lead_pat[n];
      if (p >= PATTERN_COUNT) begin
        halt = 1'b1;
      end else begin
        pos = step_pos[n][p];
        s   = blink_step(p, pos);
        steps_predicted++;
        step_pos[n][p] = pos + 1'b1;
        case (s.kind)
          KIND_LOOP: step_pos[n][p] = POS_FIRST;
          KIND_STOP: begin
            step_pos[n][p] = POS_STOPPED;
            pick_lead(n);
          end
          default: begin
            lit[n] = s.lvl;
            if (s.ms != '0) begin
              ms_left[n] = s.ms;
              halt       = 1'b1;
            end
          end
        endcase
      end
    end
  endfunction

  function automatic result_t predict_levels(logic [OP_W-1:0] op, logic [LED_W-1:0] led,
                                             logic [PAT_W-1:0] pat);
    result_t r;
    r.accepted = 1'b0;
    if (op == OP_TICK) begin
      r.accepted = 1'b1;
      for (int i = 0; i < LED_COUNT; i++) begin
        if (ms_left[i] != '0) begin
          ms_left[i] = ms_left[i] - 1'b1;
          if (ms_left[i] == '0) begin
            play_steps(i);
          end
        end
      end
    end else if ((op == OP_RUN || op == OP_STOP) && led < LED_COUNT && pat < PATTERN_COUNT) begin
      r.accepted = 1'b1;
      if (op == OP_RUN) begin
        step_pos[led][pat] = POS_FIRST;
        pick_lead(led);
        if (lead_pat[led] == pat) begin
          play_steps(led);
        end
      end else begin
        step_pos[led][pat] = POS_STOPPED;
        pick_lead(led);
        play_steps(led);
      end
    end
    r.led_levels = '0;
    for (int i = 0; i < LED_COUNT && i < LEVELS_W; i++) begin
      r.led_levels[i] = lit[i];
    end
    r.active_pattern = (led < LED_COUNT) ? lead_pat[led] : NONE_ACTIVE;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_enable = 1'b1;
      for (int n = 0; n < LED_COUNT; n++) begin
        for (int p = 0; p < PATTERN_COUNT; p++) begin
          step_pos[n][p] = POS_STOPPED;
        end
        lead_pat[n] = NONE_ACTIVE;
        ms_left[n]  = '0;
        lit[n]      = 1'b0;
      end
      levels_due.delete();
    end else begin
      if (cfg_we) begin
        seq_enable = cfg_wdata;
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        levels_due.push_back(predict_levels(cmd_mon.op, cmd_mon.led, cmd_mon.pattern));
      end
      if (res_mon.valid && res_mon.ready) begin
        seen.led_levels     = res_mon.led_levels;
        seen.active_pattern = res_mon.active_pattern;
        seen.accepted       = res_mon.accepted;
        results_checked++;
        if (levels_due.size() == 0) begin
          note_failure($sformatf("result item with none expected: levels %b active %0d acc %b",
                                 seen.led_levels, seen.active_pattern, seen.accepted));
        end else begin
          due = levels_due.pop_front();
          if (seen.led_levels !== due.led_levels || seen.active_pattern !== due.active_pattern ||
              seen.accepted !== due.accepted) begin
            note_failure($sformatf(
              "levels exp %b got %b, active exp %0d got %0d, accepted exp %b got %b",
              due.led_levels, seen.led_levels, due.active_pattern, seen.active_pattern,
              due.accepted, seen.accepted));
          end
        end
      end
    end
    results_pending = levels_due.size();
  end
endmodule

// ===== tb/sv/tb_led_priority_sequencer_unit.sv =====
// testbench top: clock, reset, item stimulus, enable writes and the final verdict
`timescale 1ns / 1ps
module tb_led_priority_sequencer_unit;
  import lps_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  int   mismatch_count;
  int   results_pending;
  int   results_checked;
  int   steps_predicted;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   long_hold_req = 1'b0;
  int   quiet_cycles  = 0;
  int   ticks_sent    = 0;
  int   cmds_sent     = 0;
  int   bad_sent      = 0;

  lps_in_if  cmd_ch ();
  lps_out_if res_ch ();

  led_priority_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lps_result_check level_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_mon        (cmd_ch),
    .res_mon        (res_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending),
    .results_checked(results_checked),
    .steps_predicted(steps_predicted)
  );

  always #2 clk = ~clk;

  // result side ready, with one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [LED_W-1:0] led,
                           logic [PAT_W-1:0] pat);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.op      <= op;
    cmd_ch.led     <= led;
    cmd_ch.pattern <= pat;
    @(posedge clk);
    while (!(cmd_ch.valid && cmd_ch.ready)) begin
      @(posedge clk);
    end
    if (op == OP_TICK) begin
      ticks_sent++;
    end else begin
      cmds_sent++;
      if (op > OP_STOP || led >= LED_COUNT || pat >= PATTERN_COUNT) begin
        bad_sent++;
      end
    end
  endtask

  task automatic send_random(int count, int hold_at);
    int               r;
    logic [OP_W-1:0]  op;
    logic [LED_W-1:0] led;
    logic [PAT_W-1:0] pat;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 74) begin
        op  = OP_TICK;
        led = LED_W'($urandom_range(7));
        pat = PAT_W'($urandom_range(7));
      end else if (r < 93) begin
        op  = ($urandom_range(99) < 65) ? OP_RUN : OP_STOP;
        led = LED_W'($urandom_range(LED_COUNT - 1));
        pat = PAT_W'($urandom_range(PATTERN_COUNT - 1));
      end else begin
        op  = OP_W'($urandom_range(3));
        led = LED_W'($urandom_range(7));
        pat = PAT_W'($urandom_range(7));
      end
      if (k == hold_at) begin
        long_hold_req = 1'b1;
      end
      send_item(op, led, pat);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (results_pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_enable(logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.op      <= OP_RUN;
    cmd_ch.led     <= '0;
    cmd_ch.pattern <= '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    write_enable(1'b1);

    // directed: pattern handover, priority, invalid fields, unused op
    send_item(OP_TICK,  3'd0, 3'd0);
    send_item(OP_RUN,   3'd0, 3'd5);
    send_item(OP_TICK,  3'd0, 3'd0);
    send_item(OP_RUN,   3'd4, 3'd0);
    send_item(OP_RUN,   3'd4, 3'd3);
    send_item(OP_STOP,  3'd4, 3'd0);
    send_item(OP_RUN,   3'd1, 3'd2);
    send_item(OP_RUN,   3'd2, 3'd4);
    send_item(OP_RUN,   3'd3, 3'd1);
    send_item(OP_RUN,   3'd4, 3'd7);
    send_item(OP_STOP,  3'd3, 3'd6);
    send_item(OP_RUN,   3'd5, 3'd0);
    send_item(OP_STOP,  3'd7, 3'd5);
    send_item(OP_SPARE, 3'd0, 3'd0);
    send_item(OP_SPARE, 3'd7, 3'd7);
    send_item(OP_TICK,  3'd7, 3'd7);
    send_item(OP_STOP,  3'd1, 3'd2);
    send_item(OP_STOP,  3'd2, 3'd0);
    send_item(OP_RUN,   3'd3, 3'd5);
    send_item(OP_RUN,   3'd0, 3'd5);
    send_item(OP_RUN,   3'd0, 3'd4);
    send_item(OP_TICK,  3'd4, 3'd1);
    send_item(OP_STOP,  3'd0, 3'd4);
    send_item(OP_TICK,  3'd2, 3'd6);
    drain_results();

    send_idle_pct = 15;
    recv_idle_pct = 68;
    send_random(420, -1);
    drain_results();

    write_enable(1'b0);
    send_idle_pct = 68;
    recv_idle_pct = 15;
    send_random(220, -1);
    drain_results();

    write_enable(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(440, 100);
    drain_results();
    repeat (30) @(negedge clk);

    $display("sent %0d tick items and %0d command items, %0d of them invalid",
             ticks_sent, cmds_sent, bad_sent);
    $display("checked %0d result items over %0d predicted pattern steps, enable on and off",
             results_checked, steps_predicted);
    if (results_pending != 0) begin
      $display("%0d expected result items never arrived", results_pending);
    end
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/lps_pkg.sv
design/lps_in_if.sv
design/lps_step.sv
design/lps_seq.sv
design/led_priority_sequencer_unit.sv
design/lps_checker.sv
tb/sv/lps_result_check.sv
tb/sv/tb_led_priority_sequencer_unit.sv
